// File: src/byte_ring_buffer_fifo_top_assert.svh
// Assertion macros for the byte ring buffer FIFO.
// Expects signals named clk and rst_n in the including module.
`ifndef BYTE_RING_BUFFER_FIFO_TOP_ASSERT_SVH
`define BYTE_RING_BUFFER_FIFO_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BRBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define BRBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/brbf_pkg.sv
// Shared types and constants for the byte ring buffer FIFO.
// No dependencies.
`timescale 1ns / 1ps

package brbf_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int MAX_BURST_DEF   = 64;
  localparam int WRITE_LANES_DEF = 8;

  localparam int OPC_W    = 2;
  localparam int DATA_W   = 8;
  localparam int WBYTES_W = 64;
  localparam int COUNT_W  = 7;
  localparam int POS_W    = 10;

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_PEEK_AT = 2'd3
  } opcode_t;

  typedef struct packed {
    logic accept;
    logic mod_step;
    logic pchk;
    logic wr_step;
    logic rd_issue;
    logic out_byte;
    logic out_resp;
  } cmd_t;

  typedef struct packed {
    logic acc_write;
    logic acc_peek_at;
    logic acc_zero;
    logic pchk_zero;
    logic left_one;
    logic out_free;
  } stat_t;

endpackage

// File: src/byte_ring_buffer_fifo_top.sv
// Byte ring buffer FIFO with write, dequeue, peek and peek-at requests. A request
// beat is taken only when the block is idle, so each request finishes before the next.
// A write of n bytes stores one byte per cycle into the single-write byte store and
// then presents its one result beat when the output is free. Dequeue and peek
// stream bytes one per cycle after the registered read of the store, throttled
// by out_ready; a request with nothing to return presents only its result beat.
// Peek-at takes the quotient of the start position by DEPTH with a constant
// reciprocal multiply at acceptance, reduces the position in the next cycle and
// checks the length in the one after. One slot stays empty, so DEPTH-1 bytes fit.
// Depends on brbf_pkg, brbf_ctrl and brbf_dp.
`timescale 1ns / 1ps

module byte_ring_buffer_fifo_top
  import brbf_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int MAX_BURST   = MAX_BURST_DEF,
  parameter int WRITE_LANES = WRITE_LANES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPC_W-1:0]    in_opcode,
  input  logic [WBYTES_W-1:0] in_write_bytes,
  input  logic [COUNT_W-1:0]  in_byte_count,
  input  logic [POS_W-1:0]    in_start_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_data_byte,
  output logic                out_byte_valid,
  output logic [COUNT_W-1:0]  out_done_length,
  output logic                out_last,
  output logic [POS_W-1:0]    out_fill_level
);

  cmd_t  cmd;
  stat_t st;

  brbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  brbf_dp #(
    .DEPTH       (DEPTH),
    .MAX_BURST   (MAX_BURST),
    .WRITE_LANES (WRITE_LANES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_opcode),
    .in_write_bytes    (in_write_bytes),
    .in_byte_count     (in_byte_count),
    .in_start_position (in_start_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_byte_valid    (out_byte_valid),
    .out_done_length   (out_done_length),
    .out_last          (out_last),
    .out_fill_level    (out_fill_level),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

// File: src/brbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/brbf_ctrl.sv
// Controller state machine for the byte ring buffer FIFO.
// Depends on brbf_pkg (cmd_t, stat_t).
`timescale 1ns / 1ps

module brbf_ctrl
  import brbf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PCHK,
    S_WR,
    S_RD,
    S_LOAD,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept = 1'b1;
          if (st.acc_peek_at) begin
            state_nxt = S_MOD;
          end else if (st.acc_zero) begin
            state_nxt = S_RESP;
          end else if (st.acc_write) begin
            state_nxt = S_WR;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        state_nxt    = S_PCHK;
      end
      S_PCHK: begin
        cmd.pchk  = 1'b1;
        state_nxt = st.pchk_zero ? S_RESP : S_RD;
      end
      S_WR: begin
        cmd.wr_step = 1'b1;
        if (st.left_one) begin
          state_nxt = S_RESP;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LOAD;
      end
      S_LOAD: begin
        if (st.out_free) begin
          cmd.out_byte = 1'b1;
          if (st.left_one) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_resp = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// File: src/brbf_dp.sv
// Datapath for the byte ring buffer FIFO: positions, request registers,
// byte store and result register. Depends on brbf_pkg and brbf_ram.
`timescale 1ns / 1ps
`include "byte_ring_buffer_fifo_top_assert.svh"

module brbf_dp
  import brbf_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int MAX_BURST   = MAX_BURST_DEF,
  parameter int WRITE_LANES = WRITE_LANES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [OPC_W-1:0]    in_opcode,
  input  logic [WBYTES_W-1:0] in_write_bytes,
  input  logic [COUNT_W-1:0]  in_byte_count,
  input  logic [POS_W-1:0]    in_start_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_data_byte,
  output logic                out_byte_valid,
  output logic [COUNT_W-1:0]  out_done_length,
  output logic                out_last,
  output logic [POS_W-1:0]    out_fill_level,
  input  cmd_t                cmd,
  output stat_t               st
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = PW + 1;
  localparam int SW  = ((PW > COUNT_W) ? PW : COUNT_W) + 1;
  localparam int MW  = CW + POS_W - 1;
  localparam int QS  = POS_W + PW;
  localparam int PRW = 2 * POS_W + 2;
  localparam logic [COUNT_W-1:0] MAXB    = COUNT_W'(MAX_BURST);
  localparam logic [COUNT_W-1:0] LANES   = COUNT_W'(WRITE_LANES);
  localparam logic [SW-1:0]      DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0]      DEPTH_C = CW'(DEPTH);
  localparam logic [MW-1:0]      DEPTH_M = MW'(DEPTH);
  localparam logic [PRW-1:0]     RECIP   = PRW'(((1 << QS) + DEPTH - 1) / DEPTH);

  function automatic logic [PW-1:0] sub_mod(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [CW-1:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + DEPTH_C;
    end
    return d[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] add_mod(input logic [PW-1:0] a,
                                            input logic [COUNT_W-1:0] n);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(n);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] inc_mod(input logic [PW-1:0] a);
    logic [PW-1:0] r;
    r = (CW'(a) == DEPTH_C - CW'(1)) ? '0 : a + PW'(1);
    return r;
  endfunction

  logic [PW-1:0]       wp_r, rp_r, addr_r;
  logic [COUNT_W-1:0]  cnt_r, left_r, len_r;
  logic [WBYTES_W-1:0] wbytes_r;
  logic [POS_W-1:0]    start_r;
  logic [POS_W-1:0]    quot_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   data_r;
  logic                bvalid_r, last_r;
  logic [COUNT_W-1:0]  done_r;
  logic [POS_W-1:0]    fill_r;

  logic [COUNT_W-1:0] c_in, c_wr, rd_n, acc_n, pchk_n;
  logic [PW-1:0]      used, avail;
  logic               wr_fit, is_write, is_deq, is_peek_at;
  logic [PRW-1:0]     quot_prod;
  logic [DATA_W-1:0]  rdata;

  always_comb begin
    is_write   = (opcode_t'(in_opcode) == OP_WRITE);
    is_deq     = (opcode_t'(in_opcode) == OP_DEQUEUE);
    is_peek_at = (opcode_t'(in_opcode) == OP_PEEK_AT);
    c_in       = (in_byte_count > MAXB) ? MAXB : in_byte_count;
    c_wr       = (c_in > LANES) ? LANES : c_in;
    used       = sub_mod(wp_r, rp_r);
    wr_fit     = (SW'(used) + SW'(c_wr)) < DEPTH_S;
    rd_n       = (SW'(c_in) < SW'(used)) ? c_in : COUNT_W'(used);
    acc_n      = is_write ? (wr_fit ? c_wr : '0) : rd_n;
    avail      = sub_mod(wp_r, PW'(start_r));
    pchk_n     = (SW'(cnt_r) <= SW'(avail)) ? cnt_r : '0;
    quot_prod  = PRW'(in_start_position) * RECIP;
  end

  always_comb begin
    st             = '0;
    st.acc_write   = is_write;
    st.acc_peek_at = is_peek_at;
    st.acc_zero    = (acc_n == '0);
    st.pchk_zero   = (pchk_n == '0);
    st.left_one    = (left_r == COUNT_W'(1));
    st.out_free    = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (is_write && wr_fit) begin
          wp_r <= add_mod(wp_r, c_wr);
        end
        if (is_deq) begin
          rp_r <= add_mod(rp_r, rd_n);
        end
      end
      if (cmd.out_byte || cmd.out_resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_r    <= c_in;
      wbytes_r <= in_write_bytes;
      start_r  <= in_start_position;
      quot_r   <= POS_W'(quot_prod >> QS);
      left_r   <= acc_n;
      len_r    <= acc_n;
      addr_r   <= is_write ? wp_r : rp_r;
    end
    if (cmd.mod_step) begin
      start_r <= start_r - POS_W'(MW'(quot_r) * DEPTH_M);
    end
    if (cmd.pchk) begin
      left_r <= pchk_n;
      len_r  <= pchk_n;
      addr_r <= PW'(start_r);
    end
    if (cmd.wr_step) begin
      wbytes_r <= wbytes_r >> DATA_W;
      addr_r   <= inc_mod(addr_r);
      left_r   <= left_r - COUNT_W'(1);
    end
    if (cmd.rd_issue) begin
      addr_r <= inc_mod(addr_r);
    end
    if (cmd.out_byte) begin
      left_r   <= left_r - COUNT_W'(1);
      data_r   <= rdata;
      bvalid_r <= 1'b1;
      done_r   <= len_r;
      last_r   <= (left_r == COUNT_W'(1));
      fill_r   <= POS_W'(used);
    end
    if (cmd.out_resp) begin
      data_r   <= '0;
      bvalid_r <= 1'b0;
      done_r   <= len_r;
      last_r   <= 1'b1;
      fill_r   <= POS_W'(used);
    end
  end

  brbf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_step),
    .waddr (addr_r),
    .wdata (wbytes_r[DATA_W-1:0]),
    .re    (cmd.rd_issue),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_data_byte   = data_r;
  assign out_byte_valid  = bvalid_r;
  assign out_done_length = done_r;
  assign out_last        = last_r;
  assign out_fill_level  = fill_r;

  `BRBF_ASSERT_NOW(a_wr_left, cmd.wr_step, left_r != '0, "write step with no bytes left")
  `BRBF_ASSERT_NOW(a_out_left, cmd.out_byte, left_r != '0, "byte beat with no bytes left")
  `BRBF_ASSERT_NOW(a_wp_range, 1'b1, CW'(wp_r) < DEPTH_C, "write position out of range")
  `BRBF_ASSERT_NOW(a_rp_range, 1'b1, CW'(rp_r) < DEPTH_C, "read position out of range")
  `BRBF_ASSERT_NEXT(a_resp_beat, cmd.out_resp, out_valid && !out_byte_valid && out_last, "bad response beat")

endmodule

// File: dv/brbf_result_checker.sv
// Result checker for the byte ring buffer FIFO: mirrors the byte store and both ring
// positions, predicts every result beat and compares each one as it leaves the block.
// Depends on brbf_pkg.
`timescale 1ns / 1ps

module brbf_result_checker
  import brbf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OPC_W-1:0]    in_opcode,
  input  logic [WBYTES_W-1:0] in_write_bytes,
  input  logic [COUNT_W-1:0]  in_byte_count,
  input  logic [POS_W-1:0]    in_start_position,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [DATA_W-1:0]   out_data_byte,
  input  logic                out_byte_valid,
  input  logic [COUNT_W-1:0]  out_done_length,
  input  logic                out_last,
  input  logic [POS_W-1:0]    out_fill_level,
  output int                  fail_count,
  output int                  pending_beats
);

  typedef struct {
    logic [DATA_W-1:0]  data_byte;
    logic               byte_valid;
    logic [COUNT_W-1:0] done_length;
    logic               last;
    logic [POS_W-1:0]   fill_level;
  } result_beat_t;

  result_beat_t      expected_beats[$];
  logic [DATA_W-1:0] ring_mem [DEPTH_DEF];
  int unsigned       wr_pos = 0;
  int unsigned       rd_pos = 0;
  int                errors = 0;

  function automatic int unsigned held_from(int unsigned start);
    return (wr_pos + DEPTH_DEF - start) % DEPTH_DEF;
  endfunction

  function automatic void push_status(int unsigned length);
    result_beat_t b;
    b.data_byte   = '0;
    b.byte_valid  = 1'b0;
    b.done_length = COUNT_W'(length);
    b.last        = 1'b1;
    b.fill_level  = POS_W'(held_from(rd_pos));
    expected_beats.push_back(b);
  endfunction

  function automatic void push_bytes(int unsigned start, int unsigned n);
    result_beat_t b;
    if (n == 0) begin
      push_status(0);
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      b.data_byte   = ring_mem[(start + i) % DEPTH_DEF];
      b.byte_valid  = 1'b1;
      b.done_length = COUNT_W'(n);
      b.last        = (i + 1 == n);
      b.fill_level  = POS_W'(held_from(rd_pos));
      expected_beats.push_back(b);
    end
  endfunction

  function automatic void predict_request(opcode_t op, logic [WBYTES_W-1:0] wb,
                                          logic [COUNT_W-1:0] count_in,
                                          logic [POS_W-1:0] start_in);
    int unsigned cnt, held, n, first_pos;
    cnt  = (count_in > MAX_BURST_DEF) ? MAX_BURST_DEF : count_in;
    held = held_from(rd_pos);
    case (op)
      OP_WRITE: begin
        if (cnt > WRITE_LANES_DEF) cnt = WRITE_LANES_DEF;
        n = 0;
        if (DEPTH_DEF - held > cnt) begin
          for (int unsigned i = 0; i < cnt; i++)
            ring_mem[(wr_pos + i) % DEPTH_DEF] = wb[8*i +: 8];
          wr_pos = (wr_pos + cnt) % DEPTH_DEF;
          n = cnt;
        end
        push_status(n);
      end
      OP_DEQUEUE, OP_PEEK: begin
        first_pos = rd_pos;
        n = (cnt < held) ? cnt : held;
        if (op == OP_DEQUEUE) rd_pos = (rd_pos + n) % DEPTH_DEF;
        push_bytes(first_pos, n);
      end
      default: begin
        first_pos = start_in % DEPTH_DEF;
        push_bytes(first_pos, (cnt > held_from(first_pos)) ? 0 : cnt);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_beat_t exp_b;
    if (!rst_n) begin
      wr_pos = 0;
      rd_pos = 0;
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          exp_b = expected_beats.pop_front();
          check_field("data_byte", exp_b.data_byte, out_data_byte);
          check_field("byte_valid", exp_b.byte_valid, out_byte_valid);
          check_field("done_length", exp_b.done_length, out_done_length);
          check_field("last", exp_b.last, out_last);
          check_field("fill_level", exp_b.fill_level, out_fill_level);
        end
      end
      if (in_valid && in_ready)
        predict_request(opcode_t'(in_opcode), in_write_bytes, in_byte_count,
                        in_start_position);
    end
    fail_count    <= errors;
    pending_beats <= expected_beats.size();
  end

endmodule

// File: dv/tb_byte_ring_buffer_fifo_top.sv
// Testbench top for the byte ring buffer FIFO: drives directed and random requests
// under several idle and stall mixes and gives the verdict.
// Depends on brbf_pkg, byte_ring_buffer_fifo_top and brbf_result_checker.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_fifo_top;
  import brbf_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASE_ITEMS     = 10;

  logic                clk               = 1'b0;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_ready;
  logic [OPC_W-1:0]    in_opcode         = '0;
  logic [WBYTES_W-1:0] in_write_bytes    = '0;
  logic [COUNT_W-1:0]  in_byte_count     = '0;
  logic [POS_W-1:0]    in_start_position = '0;
  logic                out_valid;
  logic                out_ready         = 1'b0;
  logic [DATA_W-1:0]   out_data_byte;
  logic                out_byte_valid;
  logic [COUNT_W-1:0]  out_done_length;
  logic                out_last;
  logic [POS_W-1:0]    out_fill_level;

  int          fail_total;
  int          pending_beats;
  int          quiet_cycles  = 0;
  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  logic        hold_off_go   = 1'b0;
  int unsigned trk_wr        = 0;
  int unsigned trk_rd        = 0;
  int unsigned trk_total     = 0;

  always #10 clk = ~clk;

  byte_ring_buffer_fifo_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_write_bytes    (in_write_bytes),
    .in_byte_count     (in_byte_count),
    .in_start_position (in_start_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_byte_valid    (out_byte_valid),
    .out_done_length   (out_done_length),
    .out_last          (out_last),
    .out_fill_level    (out_fill_level)
  );

  brbf_result_checker u_result_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_write_bytes    (in_write_bytes),
    .in_byte_count     (in_byte_count),
    .in_start_position (in_start_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_byte_valid    (out_byte_valid),
    .out_done_length   (out_done_length),
    .out_last          (out_last),
    .out_fill_level    (out_fill_level),
    .fail_count        (fail_total),
    .pending_beats     (pending_beats)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // hold off the sink for a long stretch once asked, else stall at random
  initial begin
    int hold_cnt;
    bit hold_done;
    hold_cnt  = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_done) begin
        hold_cnt++;
        hold_done = (hold_cnt >= HOLD_OFF_CYCLES);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  function automatic int unsigned held_bytes();
    return (trk_wr + DEPTH_DEF - trk_rd) % DEPTH_DEF;
  endfunction

  task automatic offer_request(input opcode_t op, input logic [WBYTES_W-1:0] wb,
                               input logic [COUNT_W-1:0] cnt,
                               input logic [POS_W-1:0] start_pos);
    int unsigned sat, held;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_write_bytes    <= wb;
    in_byte_count     <= cnt;
    in_start_position <= start_pos;
    do @(posedge clk); while (!in_ready);
    // track the ring positions so peek-at never lands on unwritten bytes
    sat  = (cnt > MAX_BURST_DEF) ? MAX_BURST_DEF : cnt;
    held = held_bytes();
    if (op == OP_WRITE) begin
      if (sat > WRITE_LANES_DEF) sat = WRITE_LANES_DEF;
      if (DEPTH_DEF - held > sat) begin
        trk_wr    = (trk_wr + sat) % DEPTH_DEF;
        trk_total = trk_total + sat;
      end
    end else if (op == OP_DEQUEUE) begin
      trk_rd = (trk_rd + ((sat < held) ? sat : held)) % DEPTH_DEF;
    end
  endtask

  task automatic send_random(input int wr_pct, input int deq_pct, input int peek_pct);
    opcode_t             op;
    logic [COUNT_W-1:0]  cnt;
    logic [POS_W-1:0]    start_pos;
    int unsigned         pick, avail;
    pick      = $urandom_range(99);
    start_pos = POS_W'($urandom);
    cnt = ($urandom_range(5) == 0) ? COUNT_W'($urandom_range(127))
                                   : COUNT_W'($urandom_range(MAX_BURST_DEF));
    if (pick < wr_pct) begin
      op = OP_WRITE;
      if ($urandom_range(4) != 0) cnt = COUNT_W'($urandom_range(WRITE_LANES_DEF, 1));
    end else if (pick < wr_pct + deq_pct) begin
      op = OP_DEQUEUE;
    end else if (pick < wr_pct + deq_pct + peek_pct) begin
      op = OP_PEEK;
    end else begin
      op = OP_PEEK_AT;
      if (trk_total < DEPTH_DEF) begin
        if (trk_wr == 0 || $urandom_range(7) == 0) start_pos = POS_W'(trk_wr);
        else start_pos = POS_W'($urandom_range(trk_wr - 1));
      end
      avail = (trk_wr + DEPTH_DEF - start_pos) % DEPTH_DEF;
      if ($urandom_range(3) != 0)
        cnt = COUNT_W'($urandom_range((avail < MAX_BURST_DEF) ? avail : MAX_BURST_DEF));
    end
    offer_request(op, {$urandom, $urandom}, cnt, start_pos);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    offer_request(OP_DEQUEUE, '0, 7'd5, '0);
    offer_request(OP_PEEK, '0, 7'd3, '0);
    offer_request(OP_PEEK_AT, '0, 7'd1, POS_W'(trk_wr));
    offer_request(OP_WRITE, '1, 7'd0, '0);
    offer_request(OP_WRITE, '1, 7'd8, '0);
    offer_request(OP_WRITE, '0, 7'd127, '1);
    offer_request(OP_WRITE, 64'h0123_4567_89AB_CDEF, 7'd3, '0);
    offer_request(OP_WRITE, {$urandom, $urandom}, 7'd9, '0);
    offer_request(OP_PEEK, '0, 7'd0, '0);
    offer_request(OP_PEEK, '0, 7'd64, '0);
    offer_request(OP_PEEK_AT, '0, 7'd64, 10'd0);
    offer_request(OP_PEEK_AT, '0, 7'd25, 10'd2);
    offer_request(OP_PEEK_AT, '0, 7'd127, 10'd5);
    offer_request(OP_PEEK_AT, '0, 7'd0, POS_W'(trk_wr));
    offer_request(OP_PEEK_AT, '0, 7'd1, POS_W'(trk_wr - 1));
    offer_request(OP_DEQUEUE, '0, 7'd1, '0);
    offer_request(OP_DEQUEUE, '0, 7'd127, '0);
    offer_request(OP_DEQUEUE, '0, 7'd64, '0);
    offer_request(OP_PEEK, '0, 7'd64, '0);
    offer_request(OP_WRITE, {$urandom, $urandom}, 7'd8, '0);

    // fill to the brim with no idling, then push writes against a full ring
    while (held_bytes() < DEPTH_DEF - WRITE_LANES_DEF) begin
      if ($urandom_range(9) == 0)
        send_random(0, 0, 50);
      else
        offer_request(OP_WRITE, {$urandom, $urandom},
                      ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(7, 1))
                                               : COUNT_W'(WRITE_LANES_DEF),
                      POS_W'($urandom));
    end
    repeat (10) send_random(100, 0, 0);

    src_idle_pct  = 74;
    snk_stall_pct = 0;
    repeat (PHASE_ITEMS) send_random(35, 30, 15);

    src_idle_pct  = 0;
    snk_stall_pct = 74;
    hold_off_go   = 1'b1;
    repeat (PHASE_ITEMS) send_random(35, 30, 15);

    src_idle_pct  = 33;
    snk_stall_pct = 33;
    repeat (PHASE_ITEMS) send_random(35, 30, 15);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_total == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
